@@ design/cha_pkg.sv @@
// ----------------------------------------------------------------------------
// cha_pkg: shared constants, types and helpers for the convex hull area core
// Holds the sizing constants, the controller/datapath command and status
// bundles, and the coordinate helpers used by the datapath.
// ----------------------------------------------------------------------------
package cha_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int AREA_BITS  = 50;

  localparam int ADDR_BITS = $clog2(MAX_POINTS);
  localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
  localparam int W_BITS    = CNT_BITS + 1;
  localparam int EXT_BITS  = CNT_BITS + 2;
  localparam int PT_BITS   = 2 * COORD_BITS;
  localparam int REL_BITS  = COORD_BITS + 1;
  localparam int OPD_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS = 2 * OPD_BITS;
  localparam int DIFF_BITS = PROD_BITS + 1;
  localparam int L1_BITS   = REL_BITS + 1;

  // operand selection for the shared cross product unit
  localparam logic [1:0] MODE_SORT = 2'd0;
  localparam logic [1:0] MODE_TURN = 2'd1;
  localparam logic [1:0] MODE_AREA = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clear_set;
    logic       sort_init;
    logic       next_pass;
    logic       next_run;
    logic       merge_rd;
    logic       merge_wr;
    logic       op_load;
    logic [1:0] mode;
    logic       scan_init;
    logic       scan_rd;
    logic       scan_latch;
    logic       skip;
    logic       stk_rd;
    logic       push;
    logic       pop;
    logic       area_init;
    logic       area_rd;
    logic       acc_add;
    logic       out_load;
  } cha_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic run_done;
    logic pass_end;
    logic scan_end;
    logic v_zero;
    logic top_zero;
    logic turn_left;
    logic area_end;
    logic out_free;
  } cha_stat_t;

  function automatic logic signed [REL_BITS-1:0] rel_coord(
    input logic [COORD_BITS-1:0] c,
    input logic [COORD_BITS-1:0] a
  );
    rel_coord = $signed({c[COORD_BITS-1], c}) - $signed({a[COORD_BITS-1], a});
  endfunction

  function automatic logic signed [OPD_BITS-1:0] widen(
    input logic signed [REL_BITS-1:0] v
  );
    widen = $signed({v[REL_BITS-1], v});
  endfunction

  function automatic logic [L1_BITS-1:0] l1_norm(
    input logic signed [REL_BITS-1:0] vx,
    input logic signed [REL_BITS-1:0] vy
  );
    logic [REL_BITS-1:0] ax;
    logic [REL_BITS-1:0] ay;
    ax = vx[REL_BITS-1] ? $unsigned(-vx) : $unsigned(vx);
    ay = vy[REL_BITS-1] ? $unsigned(-vy) : $unsigned(vy);
    l1_norm = {1'b0, ax} + {1'b0, ay};
  endfunction

endpackage

@@ design/cha_ram.sv @@
// ----------------------------------------------------------------------------
// cha_ram: generic RAM, one write port and two registered read ports
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module cha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ design/cha_datapath.sv @@
// ----------------------------------------------------------------------------
// cha_datapath: point store, merge sort, hull stack and area accumulator
// Holds every memory of the core, its data and pointer registers and the
// shared cross product unit; acts only on commands from the controller.
// ----------------------------------------------------------------------------
module cha_datapath import cha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cha_cmd_t              cmd,
  output cha_stat_t             stat,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [AREA_BITS-1:0]  twice_area,
  output logic                  too_many
);

  logic [CNT_BITS-1:0]   cnt;
  logic [COORD_BITS-1:0] anc_x;
  logic [COORD_BITS-1:0] anc_y;
  logic                  ovf;
  logic [W_BITS-1:0]     w;
  logic [CNT_BITS-1:0]   mid;
  logic [CNT_BITS-1:0]   hi;
  logic [CNT_BITS-1:0]   pi;
  logic [CNT_BITS-1:0]   pj;
  logic [CNT_BITS-1:0]   pk;
  logic [CNT_BITS-1:0]   idx;
  logic [CNT_BITS-1:0]   top;
  logic                  src_sel;
  logic [PT_BITS-1:0]    v_pt;

  logic signed [OPD_BITS-1:0]  op_a0, op_b0, op_a1, op_b1;
  logic                        zp, zq, l1_less;
  logic signed [PROD_BITS-1:0] prod0, prod1;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [DIFF_BITS-1:0] acc;

  logic full;
  logic new_anchor;
  logic [W_BITS-1:0]   w_new;
  logic [EXT_BITS-1:0] run_base;

  logic                 a_we, b_we, a_re, b_re, s_re;
  logic [ADDR_BITS-1:0] a_waddr, rd_addr0, rd_addr1, s_raddr0, s_raddr1;
  logic [PT_BITS-1:0]   a_wdata, a_rd0, a_rd1, b_rd0, b_rd1, s_rd0, s_rd1;
  logic [PT_BITS-1:0]   src_rd0, src_rd1, merge_data;
  logic [CNT_BITS-1:0]  top_m1, top_m2, idx_p1;

  logic signed [REL_BITS-1:0] px, py, qx, qy, vx, vy;
  logic signed [OPD_BITS-1:0] n_a0, n_b0, n_a1, n_b1;
  logic                       diff_pos, diff_neg, ahead, take_j;

  function automatic logic [CNT_BITS-1:0] clamp_n(
    input logic [EXT_BITS-1:0] v,
    input logic [CNT_BITS-1:0] n
  );
    clamp_n = (v < EXT_BITS'(n)) ? v[CNT_BITS-1:0] : n;
  endfunction

  assign full       = (cnt == CNT_BITS'(MAX_POINTS));
  assign new_anchor = (cnt == '0) || ($signed(point_y) < $signed(anc_y)) ||
                      ((point_y == anc_y) && ($signed(point_x) < $signed(anc_x)));
  assign w_new      = cmd.sort_init ? W_BITS'(1) : {w[W_BITS-2:0], 1'b0};
  assign run_base   = EXT_BITS'(hi);

  // memories: the point store ping-pongs between A and B during the sort
  assign a_we     = (cmd.load && !full) || (cmd.merge_wr && src_sel);
  assign b_we     = cmd.merge_wr && !src_sel;
  assign a_waddr  = cmd.load ? cnt[ADDR_BITS-1:0] : pk[ADDR_BITS-1:0];
  assign a_wdata  = cmd.load ? {point_x, point_y} : merge_data;
  assign a_re     = (cmd.merge_rd || cmd.scan_rd) && !src_sel;
  assign b_re     = (cmd.merge_rd || cmd.scan_rd) && src_sel;
  assign rd_addr0 = cmd.merge_rd ? pi[ADDR_BITS-1:0] : idx[ADDR_BITS-1:0];
  assign rd_addr1 = pj[ADDR_BITS-1:0];
  assign src_rd0  = src_sel ? b_rd0 : a_rd0;
  assign src_rd1  = src_sel ? b_rd1 : a_rd1;

  assign top_m1   = top - CNT_BITS'(1);
  assign top_m2   = top - CNT_BITS'(2);
  assign idx_p1   = idx + CNT_BITS'(1);
  assign s_re     = cmd.stk_rd || cmd.area_rd;
  assign s_raddr0 = cmd.stk_rd ? top_m1[ADDR_BITS-1:0] : idx[ADDR_BITS-1:0];
  assign s_raddr1 = cmd.stk_rd ? top_m2[ADDR_BITS-1:0] : idx_p1[ADDR_BITS-1:0];

  cha_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .re(a_re),
    .raddr0(rd_addr0), .raddr1(rd_addr1), .rdata0(a_rd0), .rdata1(a_rd1)
  );

  cha_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(pk[ADDR_BITS-1:0]), .wdata(merge_data), .re(b_re),
    .raddr0(rd_addr0), .raddr1(rd_addr1), .rdata0(b_rd0), .rdata1(b_rd1)
  );

  cha_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_ram_stack (
    .clk(clk), .we(cmd.push), .waddr(top[ADDR_BITS-1:0]), .wdata(v_pt), .re(s_re),
    .raddr0(s_raddr0), .raddr1(s_raddr1), .rdata0(s_rd0), .rdata1(s_rd1)
  );

  // operand selection for the shared unit: always a0*b0 - a1*b1
  always_comb begin
    px = '0;
    py = '0;
    qx = '0;
    qy = '0;
    vx = rel_coord(v_pt[PT_BITS-1:COORD_BITS], anc_x);
    vy = rel_coord(v_pt[COORD_BITS-1:0], anc_y);
    case (cmd.mode)
      MODE_SORT: begin
        px = rel_coord(src_rd1[PT_BITS-1:COORD_BITS], anc_x);
        py = rel_coord(src_rd1[COORD_BITS-1:0], anc_y);
        qx = rel_coord(src_rd0[PT_BITS-1:COORD_BITS], anc_x);
        qy = rel_coord(src_rd0[COORD_BITS-1:0], anc_y);
      end
      MODE_TURN: begin
        px = rel_coord(s_rd0[PT_BITS-1:COORD_BITS], anc_x);
        py = rel_coord(s_rd0[COORD_BITS-1:0], anc_y);
        if (top_m2[CNT_BITS-1] == 1'b0 && top >= CNT_BITS'(2)) begin
          qx = rel_coord(s_rd1[PT_BITS-1:COORD_BITS], anc_x);
          qy = rel_coord(s_rd1[COORD_BITS-1:0], anc_y);
        end
      end
      MODE_AREA: begin
        px = rel_coord(s_rd0[PT_BITS-1:COORD_BITS], anc_x);
        py = rel_coord(s_rd0[COORD_BITS-1:0], anc_y);
        qx = rel_coord(s_rd1[PT_BITS-1:COORD_BITS], anc_x);
        qy = rel_coord(s_rd1[COORD_BITS-1:0], anc_y);
      end
      default: begin
        px = '0;
      end
    endcase
    if (cmd.mode == MODE_TURN) begin
      // b = top, a = second (or the anchor), c = candidate
      n_a0 = widen(px) - widen(qx);
      n_b0 = widen(vy) - widen(qy);
      n_a1 = widen(py) - widen(qy);
      n_b1 = widen(vx) - widen(qx);
    end else begin
      n_a0 = widen(px);
      n_b0 = widen(qy);
      n_a1 = widen(py);
      n_b1 = widen(qx);
    end
  end

  assign diff_pos = !diff[DIFF_BITS-1] && (diff != '0);
  assign diff_neg = diff[DIFF_BITS-1];
  assign ahead    = (zp && zq) ? 1'b0 :
                    zp         ? 1'b1 :
                    zq         ? 1'b0 :
                    diff_pos   ? 1'b1 :
                    diff_neg   ? 1'b0 : l1_less;
  assign take_j   = (pi == mid) ? 1'b1 : (pj == hi) ? 1'b0 : ahead;
  assign merge_data = take_j ? src_rd1 : src_rd0;

  // shared cross product unit, one register per step
  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      op_a0   <= n_a0;
      op_b0   <= n_b0;
      op_a1   <= n_a1;
      op_b1   <= n_b1;
      zp      <= (px == '0) && (py == '0);
      zq      <= (qx == '0) && (qy == '0);
      l1_less <= l1_norm(px, py) < l1_norm(qx, qy);
    end
    prod0 <= op_a0 * op_b0;
    prod1 <= op_a1 * op_b1;
    diff  <= $signed({prod0[PROD_BITS-1], prod0}) - $signed({prod1[PROD_BITS-1], prod1});
    if (cmd.scan_latch) begin
      v_pt <= src_rd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      anc_x      <= '0;
      anc_y      <= '0;
      ovf        <= 1'b0;
      w          <= '0;
      mid        <= '0;
      hi         <= '0;
      pi         <= '0;
      pj         <= '0;
      pk         <= '0;
      idx        <= '0;
      top        <= '0;
      src_sel    <= 1'b0;
      acc        <= '0;
      out_valid  <= 1'b0;
      twice_area <= '0;
      too_many   <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + CNT_BITS'(1);
          if (new_anchor) begin
            anc_x <= point_x;
            anc_y <= point_y;
          end
        end
      end
      if (cmd.sort_init || cmd.next_pass) begin
        w       <= w_new;
        mid     <= clamp_n(EXT_BITS'(w_new), cnt);
        hi      <= clamp_n(EXT_BITS'(w_new) << 1, cnt);
        pi      <= '0;
        pj      <= clamp_n(EXT_BITS'(w_new), cnt);
        pk      <= '0;
        src_sel <= cmd.sort_init ? 1'b0 : !src_sel;
      end
      if (cmd.next_run) begin
        mid <= clamp_n(run_base + EXT_BITS'(w), cnt);
        hi  <= clamp_n(run_base + (EXT_BITS'(w) << 1), cnt);
        pi  <= hi;
        pj  <= clamp_n(run_base + EXT_BITS'(w), cnt);
      end
      if (cmd.merge_wr) begin
        pk <= pk + CNT_BITS'(1);
        if (take_j) begin
          pj <= pj + CNT_BITS'(1);
        end else begin
          pi <= pi + CNT_BITS'(1);
        end
      end
      if (cmd.scan_init) begin
        idx <= '0;
        top <= '0;
      end
      if (cmd.skip) begin
        idx <= idx_p1;
      end
      if (cmd.push) begin
        top <= top + CNT_BITS'(1);
        idx <= idx_p1;
      end
      if (cmd.pop) begin
        top <= top_m1;
      end
      if (cmd.area_init) begin
        idx <= '0;
        acc <= '0;
      end
      if (cmd.acc_add) begin
        acc <= acc + diff;
        idx <= idx_p1;
      end
      if (cmd.out_load) begin
        twice_area <= acc[DIFF_BITS-1] ? '0 : acc[AREA_BITS-1:0];
        too_many   <= ovf;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear_set) begin
        cnt   <= '0;
        anc_x <= '0;
        anc_y <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  assign stat.sort_done = ({1'b0, cnt} <= w);
  assign stat.run_done  = (pi == mid) && (pj == hi);
  assign stat.pass_end  = (pi == cnt);
  assign stat.scan_end  = (idx == cnt);
  assign stat.v_zero    = (v_pt == {anc_x, anc_y});
  assign stat.top_zero  = (top == '0);
  assign stat.turn_left = diff_pos;
  assign stat.area_end  = ({1'b0, idx} + W_BITS'(1)) >= {1'b0, top};
  assign stat.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_BITS'(MAX_POINTS))
    else $error("point count beyond capacity");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> full)
    else $error("overflow flag without a full store");
  a_run_ptrs: assert property (@(posedge clk) disable iff (rst)
    (pi <= mid) && (pj <= hi) && (mid <= hi))
    else $error("merge pointers left their runs");
  a_acc_sign: assert property (@(posedge clk) disable iff (rst)
    !acc[DIFF_BITS-1])
    else $error("hull area sum went negative");
`endif

endmodule

@@ design/cha_ctrl.sv @@
// ----------------------------------------------------------------------------
// cha_ctrl: sequencer for load, merge sort, Graham scan and area sum
// Steps through the phases and issues one command bundle per cycle.
// ----------------------------------------------------------------------------
module cha_ctrl import cha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last_point,
  input  cha_stat_t stat,
  output logic      in_stall,
  output cha_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SORT   = 5'd1;
  localparam logic [4:0] ST_P_CHK  = 5'd2;
  localparam logic [4:0] ST_M_RD   = 5'd3;
  localparam logic [4:0] ST_M_OP   = 5'd4;
  localparam logic [4:0] ST_M_MUL  = 5'd5;
  localparam logic [4:0] ST_M_DIF  = 5'd6;
  localparam logic [4:0] ST_M_WR   = 5'd7;
  localparam logic [4:0] ST_M_CHK  = 5'd8;
  localparam logic [4:0] ST_M_RUN  = 5'd9;
  localparam logic [4:0] ST_C_INIT = 5'd10;
  localparam logic [4:0] ST_C_RD   = 5'd11;
  localparam logic [4:0] ST_C_LAT  = 5'd12;
  localparam logic [4:0] ST_C_CHK  = 5'd13;
  localparam logic [4:0] ST_K_RD   = 5'd14;
  localparam logic [4:0] ST_K_OP   = 5'd15;
  localparam logic [4:0] ST_K_MUL  = 5'd16;
  localparam logic [4:0] ST_K_DIF  = 5'd17;
  localparam logic [4:0] ST_K_DEC  = 5'd18;
  localparam logic [4:0] ST_A_INIT = 5'd19;
  localparam logic [4:0] ST_A_RD   = 5'd20;
  localparam logic [4:0] ST_A_OP   = 5'd21;
  localparam logic [4:0] ST_A_MUL  = 5'd22;
  localparam logic [4:0] ST_A_DIF  = 5'd23;
  localparam logic [4:0] ST_A_ACC  = 5'd24;
  localparam logic [4:0] ST_DONE   = 5'd25;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept && last_point) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort_init = 1'b1;
        state_next    = ST_P_CHK;
      end
      ST_P_CHK: begin
        state_next = stat.sort_done ? ST_C_INIT : ST_M_RD;
      end
      ST_M_RD: begin
        cmd.merge_rd = 1'b1;
        state_next   = ST_M_OP;
      end
      ST_M_OP: begin
        cmd.op_load = 1'b1;
        cmd.mode    = MODE_SORT;
        state_next  = ST_M_MUL;
      end
      ST_M_MUL: state_next = ST_M_DIF;
      ST_M_DIF: state_next = ST_M_WR;
      ST_M_WR: begin
        cmd.merge_wr = 1'b1;
        state_next   = ST_M_CHK;
      end
      ST_M_CHK: begin
        if (stat.run_done) begin
          cmd.next_run = 1'b1;
          state_next   = ST_M_RUN;
        end else begin
          state_next = ST_M_RD;
        end
      end
      ST_M_RUN: begin
        if (stat.pass_end) begin
          cmd.next_pass = 1'b1;
          state_next    = ST_P_CHK;
        end else begin
          state_next = ST_M_RD;
        end
      end
      ST_C_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = ST_C_RD;
      end
      ST_C_RD: begin
        if (stat.scan_end) begin
          state_next = ST_A_INIT;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_C_LAT;
        end
      end
      ST_C_LAT: begin
        cmd.scan_latch = 1'b1;
        state_next     = ST_C_CHK;
      end
      ST_C_CHK: begin
        if (stat.v_zero) begin
          cmd.skip   = 1'b1;
          state_next = ST_C_RD;
        end else begin
          state_next = ST_K_RD;
        end
      end
      ST_K_RD: begin
        if (stat.top_zero) begin
          cmd.push   = 1'b1;
          state_next = ST_C_RD;
        end else begin
          cmd.stk_rd = 1'b1;
          state_next = ST_K_OP;
        end
      end
      ST_K_OP: begin
        cmd.op_load = 1'b1;
        cmd.mode    = MODE_TURN;
        state_next  = ST_K_MUL;
      end
      ST_K_MUL: state_next = ST_K_DIF;
      ST_K_DIF: state_next = ST_K_DEC;
      ST_K_DEC: begin
        if (stat.turn_left) begin
          cmd.push   = 1'b1;
          state_next = ST_C_RD;
        end else begin
          cmd.pop    = 1'b1;
          state_next = ST_K_RD;
        end
      end
      ST_A_INIT: begin
        cmd.area_init = 1'b1;
        state_next    = ST_A_RD;
      end
      ST_A_RD: begin
        if (stat.area_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.area_rd = 1'b1;
          state_next  = ST_A_OP;
        end
      end
      ST_A_OP: begin
        cmd.op_load = 1'b1;
        cmd.mode    = MODE_AREA;
        state_next  = ST_A_MUL;
      end
      ST_A_MUL: state_next = ST_A_DIF;
      ST_A_DIF: state_next = ST_A_ACC;
      ST_A_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_A_RD;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.clear_set = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/convex_hull_area_core.sv @@
// ----------------------------------------------------------------------------
// convex_hull_area_core: twice the area of the convex hull of a point set
// Stores a set of points, sorts them by angle about the lowest point with a
// bottom-up merge sort, runs a Graham scan and sums the shoelace terms.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_stall  | point_x, point_y, last_point
//   output   | out_valid / out_stall| twice_area, too_many
//
// Loading: one point per cycle while the input is not stalled. The point with
// last_point set starts the computation: a bottom-up merge sort with the
// shared cross product unit, three registers deep, used once per compared pair;
// then the Graham scan, one hull test per stack comparison (none where the
// stack is empty); then the area sum, one shoelace term per hull edge.
// Reset: synchronous, clears the point count, anchor, overflow flag, the
// sequencer and the output valid; the memories are not cleared.
// Stalls: input stalls for the whole computation. A finished result sits in
// the output register while the next set loads; the core waits before
// writing a new result until the previous transaction has gone.
// ----------------------------------------------------------------------------
module convex_hull_area_core import cha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  last_point,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [AREA_BITS-1:0]  twice_area,
  output logic                  too_many
);

  cha_cmd_t  cmd;
  cha_stat_t stat;

  // sequencer: decide what the datapath does each cycle
  cha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_point (last_point),
    .stat       (stat),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  // datapath: memories, pointers, cross product unit and output register
  cha_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .twice_area (twice_area),
    .too_many   (too_many)
  );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the convex hull area core
// Streams point sets through the core under varied idling, predicts twice the
// hull area with an exact integer Graham scan, and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import cha_pkg::*;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } point_item_t;

  typedef struct {
    logic [AREA_BITS-1:0] area;
    logic                 over;
  } area_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] point_x = '0;
  logic [COORD_BITS-1:0] point_y = '0;
  logic                  last_point = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AREA_BITS-1:0]  twice_area;
  logic                  too_many;

  convex_hull_area_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .twice_area(twice_area), .too_many(too_many)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_item_t  pending_points[$];
  area_result_t expected_areas[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  points_sent = 0;
  int unsigned  results_seen = 0;
  bit           source_done = 1'b0;

  // predictor state: the current set, its anchor and the overflow flag
  longint set_x[$];
  longint set_y[$];
  longint anchor_x = 0;
  longint anchor_y = 0;
  bit     set_overflow = 1'b0;

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  // strict angle order about the anchor, nearer first on equal angle
  function automatic bit angle_less(longint ax, longint ay, longint bx, longint by);
    longint c;
    bit za, zb;
    za = (ax == 0 && ay == 0);
    zb = (bx == 0 && by == 0);
    if (za && zb) return 1'b0;
    if (za) return 1'b1;
    if (zb) return 1'b0;
    c = ax * by - ay * bx;
    if (c != 0) return c > 0;
    return labs(ax) + labs(ay) < labs(bx) + labs(by);
  endfunction

  function automatic logic [AREA_BITS-1:0] hull_area_of_set();
    longint rx[$], ry[$], hx[$], hy[$];
    longint tx, ty, turn, acc, ax, ay;
    int n, j, top;
    n = set_x.size();
    for (int i = 0; i < n; i++) begin
      rx.push_back(set_x[i] - anchor_x);
      ry.push_back(set_y[i] - anchor_y);
    end
    // insertion sort is stable; ties in the order give identical hulls anyway
    for (int i = 1; i < n; i++) begin
      tx = rx[i];
      ty = ry[i];
      j = i - 1;
      while (j >= 0 && angle_less(tx, ty, rx[j], ry[j])) begin
        rx[j+1] = rx[j];
        ry[j+1] = ry[j];
        j--;
      end
      rx[j+1] = tx;
      ry[j+1] = ty;
    end
    for (int i = 0; i < n; i++) begin
      if (rx[i] == 0 && ry[i] == 0) continue;
      while (hx.size() >= 1) begin
        top = hx.size();
        ax = (top >= 2) ? hx[top-2] : 0;
        ay = (top >= 2) ? hy[top-2] : 0;
        turn = (hx[top-1] - ax) * (ry[i] - ay) - (hy[top-1] - ay) * (rx[i] - ax);
        if (turn > 0) break;
        void'(hx.pop_back());
        void'(hy.pop_back());
      end
      hx.push_back(rx[i]);
      hy.push_back(ry[i]);
    end
    acc = 0;
    for (int i = 0; i + 1 < hx.size(); i++)
      acc += hx[i] * hy[i+1] - hy[i] * hx[i+1];
    if (acc < 0) acc = 0;
    return acc[AREA_BITS-1:0];
  endfunction

  // advance the predictor by one accepted point
  task automatic predict_point(point_item_t p);
    longint x, y;
    area_result_t r;
    x = longint'($signed(p.x));
    y = longint'($signed(p.y));
    if (set_x.size() < MAX_POINTS) begin
      if (set_x.size() == 0 || y < anchor_y || (y == anchor_y && x < anchor_x)) begin
        anchor_x = x;
        anchor_y = y;
      end
      set_x.push_back(x);
      set_y.push_back(y);
    end else begin
      set_overflow = 1'b1;
    end
    if (p.last) begin
      r.area = hull_area_of_set();
      r.over = set_overflow;
      expected_areas.push_back(r);
      set_x.delete();
      set_y.delete();
      anchor_x = 0;
      anchor_y = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // driver: hold a stalled transaction, otherwise advance or idle at random
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_point('{x: point_x, y: point_y, last: last_point});
        points_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          point_item_t p;
          p = pending_points.pop_front();
          point_x <= p.x;
          point_y <= p.y;
          last_point <= p.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_areas.size() == 0) begin
          report_mismatch("result with none expected");
        end else begin
          area_result_t e;
          e = expected_areas.pop_front();
          if (twice_area !== e.area)
            report_mismatch($sformatf("twice_area got %0d want %0d", twice_area, e.area));
          if (too_many !== e.over)
            report_mismatch($sformatf("too_many got %0b want %0b", too_many, e.over));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic int rand_coord(int unsigned span);
    int v;
    if (span == 0) v = $signed($urandom()) >>> (32 - COORD_BITS);
    else v = int'($urandom_range(2 * span)) - int'(span);
    return v;
  endfunction

  task automatic add_point(int x, int y, bit last);
    pending_points.push_back('{x: x[COORD_BITS-1:0], y: y[COORD_BITS-1:0], last: last});
  endtask

  // random set: mostly small, some larger, a few tiny ones
  task automatic add_random_set();
    int unsigned n, span, sel;
    sel = $urandom_range(99);
    n = (sel < 70) ? $urandom_range(1, 12) : (sel < 95) ? $urandom_range(13, 60)
        : $urandom_range(3, 5);
    span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(1, 20));
    for (int i = 0; i < n; i++)
      add_point(rand_coord(span), rand_coord(span), i == n - 1);
  endtask

  task automatic drain_all();
    wait (pending_points.size() == 0 && !in_valid && expected_areas.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN = -(1 << (COORD_BITS - 1));

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: single point, two points, collinear run, extreme square,
    // duplicates and anchor copies, collinear hull edge points
    add_point(CMAX, CMIN, 1);
    add_point(5, 5, 0); add_point(-3, 2, 1);
    add_point(0, 0, 0); add_point(1, 1, 0); add_point(2, 2, 0); add_point(3, 3, 1);
    add_point(CMIN, CMIN, 0); add_point(CMAX, CMIN, 0);
    add_point(CMAX, CMAX, 0); add_point(CMIN, CMAX, 1);
    add_point(0, 0, 0); add_point(0, 0, 0); add_point(4, 0, 0);
    add_point(4, 0, 0); add_point(0, 4, 1);
    add_point(0, 0, 0); add_point(2, 0, 0); add_point(4, 0, 0);
    add_point(4, 4, 0); add_point(2, 2, 0); add_point(0, 4, 1);
    drain_all();

    // overflow: one full store plus dropped points, the last one dropped too
    for (int i = 0; i < MAX_POINTS + 3; i++)
      add_point(rand_coord(1000), rand_coord(1000), i == MAX_POINTS + 2);
    // pause the source until everything has come back
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 81) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 81) : 0;
      while (pending_points.size() < 64) add_random_set();
      drain_all();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    source_done = 1'b1;
  end

  initial begin
    wait (source_done);
    $display("covered %0d points and %0d hull results, incl. store overflow",
             points_sent, results_seen);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("timeout after %0d results", results_seen);
    $display("status: fail");
    $finish;
  end
endmodule

@@ files.f @@
design/cha_pkg.sv
design/cha_ram.sv
design/cha_datapath.sv
design/cha_ctrl.sv
design/convex_hull_area_core.sv
tb/sv/testbench.sv
